FILE: rtl/wfpa_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator package
// Shared constants, field widths and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    localparam int MAX_PARTITIONS_DEF = 64;

    localparam int SIZE_W  = 24;
    localparam int OWNER_W = 16;
    localparam int SEG_W   = 6;

    // stream packing
    localparam int S_TDATA_W = 40;   // size, process_id
    localparam int M_TDATA_W = 8;    // segment_index, zero fill
    localparam int M_TUSER_W = 2;    // granted, table_full

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_COMMIT = 6'b001000,
        S_APPEND = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    typedef struct packed {
        logic used;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic append;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic out_busy;
    } t_status;

endpackage

FILE: rtl/worst_fit_partition_allocator.sv
// Load item: the beat is captured, S_APPEND writes the entry and S_FINISH
// loads the result register once it is free. Request item: scans
// partition_count entries at one per cycle through the single read port of the
// partition table, then S_DRAIN, S_COMMIT and S_FINISH; next beat in S_IDLE.
// One item in flight; a new beat is taken while a result waits downstream.
// Synchronous active-low reset: memory_size 0, one partition, entry 0 free.
// ----------------------------------------------------------------------------
// Worst-fit partition allocator
// Fixed-partition table with append and worst-fit allocation requests.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = wfpa_pkg::MAX_PARTITIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wfpa_pkg::SIZE_W-1:0]    i_cfg_wdata,   // memory_size
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [wfpa_pkg::S_TDATA_W-1:0] i_s_tdata,     // size[23:0], process_id[39:24]
    input  logic                           i_s_tuser,     // op
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [wfpa_pkg::M_TDATA_W-1:0] o_m_tdata,     // segment_index[5:0], zero[7:6]
    output logic [wfpa_pkg::M_TUSER_W-1:0] o_m_tuser      // granted[0], table_full[1]
);

    wfpa_pkg::t_cmd    cmd;
    wfpa_pkg::t_status status;

    wfpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wfpa_dp #(
        .MAX_PARTITIONS (MAX_PARTITIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: rtl/wfpa_ctrl.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator controller
// Sequences one item at a time: capture, then table scan and commit or
// append, then hand-off to the result register.
// ----------------------------------------------------------------------------
module wfpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_op,
    input  wfpa_pkg::t_status i_status,
    output wfpa_pkg::t_cmd    o_cmd
);

    wfpa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            wfpa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    if (i_op == wfpa_pkg::OP_REQUEST) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = wfpa_pkg::S_SCAN;
                    end else begin
                        n_state = wfpa_pkg::S_APPEND;
                    end
                end
            end
            wfpa_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.last_addr) begin
                    n_state = wfpa_pkg::S_DRAIN;
                end
            end
            // let the last read come back and be compared
            wfpa_pkg::S_DRAIN: begin
                n_state = wfpa_pkg::S_COMMIT;
            end
            wfpa_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = wfpa_pkg::S_FINISH;
            end
            wfpa_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = wfpa_pkg::S_FINISH;
            end
            wfpa_pkg::S_FINISH: begin
                // hold until the result register is free
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = wfpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wfpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/wfpa_dp.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator datapath
// Partition table memory, scan comparator with best-so-far registers,
// append logic and the result register.
// ----------------------------------------------------------------------------
module wfpa_dp #(
    parameter int MAX_PARTITIONS = wfpa_pkg::MAX_PARTITIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wfpa_pkg::t_cmd                   i_cmd,
    output wfpa_pkg::t_status                o_status,
    input  logic [wfpa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_cfg_we,
    input  logic [wfpa_pkg::SIZE_W-1:0]      i_cfg_wdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [wfpa_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [wfpa_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    localparam int ADDR_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int SIZE_W = wfpa_pkg::SIZE_W;
    localparam int OWN_W  = wfpa_pkg::OWNER_W;
    localparam int SEG_W  = wfpa_pkg::SEG_W;

    wfpa_pkg::t_entry r_mem [MAX_PARTITIONS];
    wfpa_pkg::t_entry r_rd_data;

    logic [SIZE_W-1:0] r_mem_size;
    logic [CNT_W-1:0]  r_count;
    logic              r_used0;
    logic [OWN_W-1:0]  r_owner0;

    logic [SIZE_W-1:0] r_size;
    logic [OWN_W-1:0]  r_pid;

    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_idx;

    logic              r_found;
    logic [ADDR_W-1:0] r_best;
    logic [SIZE_W-1:0] r_best_size;

    logic              r_res_granted;
    logic              r_res_full;
    logic [ADDR_W-1:0] r_res_idx;

    logic              r_out_valid;
    logic              r_out_granted;
    logic              r_out_full;
    logic [SEG_W-1:0]  r_out_seg;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_addr;
    wfpa_pkg::t_entry     w_data;
    logic [SIZE_W-1:0]    cand_size;
    logic                 cand_used;
    logic                 better;
    logic                 tbl_full;
    logic [ADDR_W+SEG_W-1:0] res_idx_ext;

    assign tbl_full = (r_count == CNT_W'(MAX_PARTITIONS));

    // entry 0 lives in registers; its size is the configured memory size
    assign cand_size = (r_rd_idx == '0) ? r_mem_size : r_rd_data.size;
    assign cand_used = (r_rd_idx == '0) ? r_used0    : r_rd_data.used;
    // larger size means larger leftover for the same request
    assign better = r_rd_vld && !cand_used && (cand_size >= r_size)
                    && (!r_found || (cand_size > r_best_size));

    assign o_status.last_addr = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign o_status.out_busy  = r_out_valid && !i_m_tready;

    always_comb begin
        w_we   = 1'b0;
        w_addr = r_count[ADDR_W-1:0];
        w_data = '{used: 1'b0, owner: '0, size: r_size};
        if (i_cmd.append && !tbl_full) begin
            w_we = 1'b1;
        end else if (i_cmd.commit && r_found && (r_best != '0)) begin
            w_we   = 1'b1;
            w_addr = r_best;
            w_data = '{used: 1'b1, owner: r_pid, size: r_best_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size  <= '0;
            r_count     <= CNT_W'(1);
            r_used0     <= 1'b0;
            r_owner0    <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_found <= 1'b0;
            end else if (better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.append && !tbl_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit && r_found && (r_best == '0)) begin
                r_used0  <= 1'b1;
                r_owner0 <= r_pid;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_size <= i_s_tdata[SIZE_W-1:0];
            r_pid  <= i_s_tdata[SIZE_W +: OWN_W];
        end
        if (i_cmd.scan_start) begin
            r_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        r_rd_idx <= r_addr;
        if (better) begin
            r_best      <= r_rd_idx;
            r_best_size <= cand_size;
        end
        if (i_cmd.append) begin
            r_res_granted <= !tbl_full;
            r_res_full    <= tbl_full;
            r_res_idx     <= tbl_full ? '0 : r_count[ADDR_W-1:0];
        end else if (i_cmd.commit) begin
            r_res_granted <= r_found;
            r_res_full    <= 1'b0;
            r_res_idx     <= r_found ? r_best : '0;
        end
        if (i_cmd.out_load) begin
            r_out_granted <= r_res_granted;
            r_out_full    <= r_res_full;
            r_out_seg     <= res_idx_ext[SEG_W-1:0];
        end
    end

    assign res_idx_ext = {{SEG_W{1'b0}}, r_res_idx};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(wfpa_pkg::M_TDATA_W - SEG_W){1'b0}}, r_out_seg};
    assign o_m_tuser  = {r_out_full, r_out_granted};

endmodule

FILE: tb/sv/worst_fit_partition_allocator_checker.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator checker
// Watches the register port and both streams, keeps its own partition table,
// works out the reply to every accepted beat and compares each reply beat
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_checker
    import wfpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,    // size[23:0], process_id[39:24]
    input  logic                 i_s_tuser,    // op
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,    // segment_index[5:0], zero[7:6]
    input  logic [M_TUSER_W-1:0] i_m_tuser,    // granted[0], table_full[1]
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int N_PART = MAX_PARTITIONS_DEF;

    typedef struct packed {
        logic             granted;
        logic             table_full;
        logic [SEG_W-1:0] segment_index;
    } t_alloc_reply;

    logic [SIZE_W-1:0]  mem_size;
    logic [SIZE_W-1:0]  part_size  [N_PART];
    logic               part_used  [N_PART];
    logic [OWNER_W-1:0] part_owner [N_PART];
    int                 part_count;

    t_alloc_reply       replies_due[$];
    t_alloc_reply       want;
    t_alloc_reply       fresh_reply;
    int                 mismatches = 0;

    // Apply one item to the table and return the reply it earns.
    function automatic t_alloc_reply place_item(input logic op,
                                                input logic [SIZE_W-1:0] want_size,
                                                input logic [OWNER_W-1:0] pid);
        t_alloc_reply       r;
        bit                 found;
        int                 best;
        logic [SIZE_W-1:0]  best_left;
        logic [SIZE_W-1:0]  avail;
        r         = '0;
        found     = 1'b0;
        best      = 0;
        best_left = '0;
        if (op == OP_LOAD) begin
            if (part_count < N_PART) begin
                part_size[part_count]  = want_size;
                part_used[part_count]  = 1'b0;
                part_owner[part_count] = '0;
                r.granted       = 1'b1;
                r.segment_index = SEG_W'(part_count);
                part_count++;
            end else begin
                r.table_full = 1'b1;
            end
        end else begin
            for (int i = 0; i < part_count; i++) begin
                // entry 0 always follows the live memory_size register
                avail = (i == 0) ? mem_size : part_size[i];
                if (!part_used[i] && avail >= want_size) begin
                    if (!found || (avail - want_size) > best_left) begin
                        found     = 1'b1;
                        best      = i;
                        best_left = avail - want_size;
                    end
                end
            end
            if (found) begin
                part_used[best]  = 1'b1;
                part_owner[best] = pid;
                r.granted        = 1'b1;
                r.segment_index  = SEG_W'(best);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mem_size   = '0;
            part_count = 1;
            for (int i = 0; i < N_PART; i++) begin
                part_size[i]  = '0;
                part_used[i]  = 1'b0;
                part_owner[i] = '0;
            end
            replies_due.delete();
        end else begin
            if (i_cfg_we)
                mem_size = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                fresh_reply = place_item(i_s_tuser, i_s_tdata[SIZE_W-1:0],
                                         i_s_tdata[SIZE_W+OWNER_W-1:SIZE_W]);
                replies_due = {replies_due, fresh_reply};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("reply beat with no item outstanding");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_m_tuser[0] !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, i_m_tuser[0]);
                        mismatches++;
                    end
                    if (i_m_tuser[1] !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, i_m_tuser[1]);
                        mismatches++;
                    end
                    if (i_m_tdata[SEG_W-1:0] !== want.segment_index) begin
                        $error("segment_index: expected %0d, got %0d",
                               want.segment_index, i_m_tdata[SEG_W-1:0]);
                        mismatches++;
                    end
                    if (i_m_tdata[M_TDATA_W-1:SEG_W] !== '0) begin
                        $error("tdata_pad: expected 0, got %0d",
                               i_m_tdata[M_TDATA_W-1:SEG_W]);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/worst_fit_partition_allocator_test.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator testbench
// Drives loads and allocation requests into the block, first a directed set
// covering ties, zero sizes, refusals and register changes, then random
// traffic over several idle and back-pressure mixes until the table fills
// and loads are refused. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_test;

    import wfpa_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 500;
    localparam int LOAD_PCT      = 6;
    localparam int SETTLE_CYCLES = 70;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;    // size[23:0], process_id[39:24]
    logic                 i_s_tuser   = 1'b0;  // op
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;           // segment_index[5:0], zero[7:6]
    logic [M_TUSER_W-1:0] o_m_tuser;           // granted[0], table_full[1]

    int fail_count;
    int pending;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    worst_fit_partition_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    worst_fit_partition_allocator_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Reply side: random stalls, or a long hold-off when one is asked for.
    initial begin
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken, with valid still high so back-to-back beats need no gap.
    task automatic submit_item(input logic op, input logic [SIZE_W-1:0] sz,
                               input logic [OWNER_W-1:0] pid);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {pid, sz};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic set_memory_size(input logic [SIZE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] last_load;
        last_load = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // memory_size still at reset: nothing fits
        submit_item(OP_REQUEST, 24'd1, 16'h0001);
        wait_all_results();
        set_memory_size(24'hFFFFFF);

        submit_item(OP_LOAD, 24'd0, 16'hFFFF);          // zero size, id ignored
        submit_item(OP_LOAD, 24'hFFFFFF, 16'h0000);
        submit_item(OP_LOAD, 24'd1000, 16'h0000);
        submit_item(OP_LOAD, 24'd1000, 16'h0000);
        submit_item(OP_LOAD, 24'h800000, 16'h0000);
        submit_item(OP_REQUEST, 24'hFFFFFF, 16'hFFFF);  // tie with entry 2, lowest wins
        submit_item(OP_REQUEST, 24'hFFFFFF, 16'h1234);
        submit_item(OP_REQUEST, 24'hFFFFFF, 16'h0001);  // no fit left
        submit_item(OP_REQUEST, 24'd1000, 16'hAAAA);
        submit_item(OP_REQUEST, 24'd1000, 16'h5555);
        submit_item(OP_REQUEST, 24'd1000, 16'h0000);
        submit_item(OP_REQUEST, 24'd1000, 16'h0002);
        submit_item(OP_REQUEST, 24'd0, 16'h8000);       // takes the empty partition
        submit_item(OP_REQUEST, 24'd0, 16'h7FFF);       // nothing free at all
        submit_item(OP_LOAD, 24'h7FFFFF, 16'h0000);
        submit_item(OP_REQUEST, 24'd0, 16'hFFFF);

        for (int p = 0; p < 4; p++) begin
            wait_all_results();
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    set_memory_size('0);
                end
                1: begin
                    send_idle_pct = 86; recv_stall_pct = 0;
                    set_memory_size(24'hFFFFFF);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 86;
                    set_memory_size(SIZE_W'($urandom));
                end
                default: begin
                    send_idle_pct = 9;  recv_stall_pct = 9;
                    set_memory_size(24'd1);
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 120)
                    holds_asked <= holds_asked + 1;
                if (p == 2 && k == 250)
                    wait_all_results();
                if ($urandom_range(0, 99) < LOAD_PCT) begin
                    // repeat the previous size now and then to build ties
                    case ($urandom_range(0, 3))
                        0:       sz = last_load;
                        1:       sz = SIZE_W'($urandom_range(0, 255));
                        2:       sz = $urandom_range(0, 1) ? '1 : '0;
                        default: sz = SIZE_W'($urandom);
                    endcase
                    last_load = sz;
                    submit_item(OP_LOAD, sz, OWNER_W'($urandom));
                end else begin
                    case ($urandom_range(0, 5))
                        0:       sz = SIZE_W'($urandom_range(0, 255));
                        1:       sz = '0;
                        default: sz = SIZE_W'($urandom);
                    endcase
                    submit_item(OP_REQUEST, sz, OWNER_W'($urandom));
                end
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
